// File: rtl/core/umdu_pkg.sv
// ============================================================================
// umdu_pkg: shared types and constants of the unsigned multiply/divide unit
// Holds the operation codes, field widths and the control and status
// structs that pass between the top level and the bit-serial engine.
// ============================================================================
`default_nettype none

package umdu_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned FIELD_W = 32;

    localparam logic [KIND_W-1:0] KIND_MUL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REM = 2'd2;

    typedef struct packed {
        logic              start;
        logic              take;
        logic [KIND_W-1:0] kind;
    } eng_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/umdu_engine.sv
// ============================================================================
// umdu_engine: bit-serial shift-and-add multiplier and restoring divider
// Retires one multiplier bit or one quotient bit per clock and holds the
// finished result until the top level takes it.
// ============================================================================
`default_nettype none

module umdu_engine #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire umdu_pkg::eng_ctrl_t   ctrl,
    input  wire logic [DATA_WIDTH-1:0] a_in,
    input  wire logic [DATA_WIDTH-1:0] b_in,
    output umdu_pkg::eng_stat_t        stat,
    output logic [DATA_WIDTH-1:0]      result
);

    localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [umdu_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [DATA_WIDTH-1:0]       a_reg, a_next;
    logic [DATA_WIDTH-1:0]       b_reg, b_next;
    logic [DATA_WIDTH-1:0]       acc_reg, acc_next;
    logic [DATA_WIDTH:0]         rem_shift;
    logic [DATA_WIDTH:0]         diff;

    assign rem_shift = {acc_reg, a_reg[DATA_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, b_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                    kind_next  = ctrl.kind;
                    a_next     = a_in;
                    b_next     = b_in;
                    acc_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (kind_reg == umdu_pkg::KIND_MUL)
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[DATA_WIDTH-2:0], 1'b0};
                    b_next = {1'b0, b_reg[DATA_WIDTH-1:1]};
                end
                else
                begin
                    if (!diff[DATA_WIDTH])
                    begin
                        acc_next = diff[DATA_WIDTH-1:0];
                    end
                    else
                    begin
                        acc_next = rem_shift[DATA_WIDTH-1:0];
                    end
                    a_next = {a_reg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = ST_IDLE;
                    if (ctrl.start)
                    begin
                        state_next = ST_RUN;
                        cnt_next   = '0;
                        kind_next  = ctrl.kind;
                        a_next     = a_in;
                        b_next     = b_in;
                        acc_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        case (kind_reg)
            umdu_pkg::KIND_MUL: result = acc_reg;
            umdu_pkg::KIND_QUO: result = a_reg;
            umdu_pkg::KIND_REM: result = (b_reg == '0) ? '1 : acc_reg;
            default:            result = '0;
        endcase
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

endmodule

`default_nettype wire

// File: rtl/core/unsigned_mul_div_unit_core.sv
// ============================================================================
// unsigned_mul_div_unit_core: bit-serial unsigned multiply / divide unit
// Low product word, quotient or remainder of two unsigned operands.
// ============================================================================
// Usage: an input transaction carries the operation kind in s_axis_tuser
// (0 multiply low word, 1 quotient, 2 remainder) and the operands in
// s_axis_tdata. One result transaction leaves on m_axis_tdata for each
// input transaction, in order. A zero divisor gives all ones for both the
// quotient and the remainder; the unused kind gives zero.
// The engine retires one operand bit per cycle in its shift registers
// while an operation runs; the finished result then passes to the output
// register, which drives m_axis_tvalid. A new transaction is taken only
// once the engine has handed its previous result over, at the earliest
// in the same cycle as that handoff.
// The output register lets the engine start the next operation while a
// result waits; if the receiver stalls further, the engine holds its
// finished result and s_axis_tready stays low until the output frees.
// Reset clears the control state: nothing in flight, no output valid.
// Operand bits above DATA_WIDTH are ignored and results are zero-extended.
// ============================================================================
`default_nettype none

module unsigned_mul_div_unit_core #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // operand_a [31:0], operand_b [63:32]
    input  wire logic [1:0]  s_axis_tuser,  // kind [1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // result [31:0]
);

    umdu_pkg::eng_ctrl_t   ctrl;
    umdu_pkg::eng_stat_t   stat;
    logic [DATA_WIDTH-1:0] eng_result;
    logic                  handoff;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_data_reg, out_data_next;

    assign handoff       = stat.done && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = stat.idle || handoff;

    assign ctrl.start = s_axis_tvalid && s_axis_tready;
    assign ctrl.take  = handoff;
    assign ctrl.kind  = s_axis_tuser;

    umdu_engine #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .a_in   (s_axis_tdata[DATA_WIDTH-1:0]),
        .b_in   (s_axis_tdata[32+DATA_WIDTH-1:32]),
        .stat   (stat),
        .result (eng_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (handoff)
        begin
            out_valid_next = 1'b1;
            out_data_next  = 32'(eng_result);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/umdu_checker.sv
// ============================================================================
// umdu_checker: port-level checks of the unsigned multiply/divide unit
// Watches the stream ports for busy behavior and output stability.
// ============================================================================
`default_nettype none

module umdu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A stalled result transaction must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result transaction changed");

    // The engine is busy right after it accepts a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while engine busy");

    a_busy_two: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 !s_axis_tready)
        else $error("engine finished too early");

    // A new result only follows a busy engine.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready, 2))
        else $error("result appeared without a finished operation");

endmodule

bind unsigned_mul_div_unit_core umdu_checker u_umdu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: sim/mul_div_checker.sv
// ============================================================================
// mul_div_checker: result checker for the unsigned multiply/divide unit
// Watches both stream channels of the unit. Each accepted input transaction
// is turned into its expected result, and each accepted output transaction
// is compared in order against the oldest expected result.
// ============================================================================

module mul_div_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [1:0]  s_axis_tuser,   // kind [1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // result [31:0]
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [umdu_pkg::KIND_W-1:0]  kind;
        logic [umdu_pkg::FIELD_W-1:0] operand_a;
        logic [umdu_pkg::FIELD_W-1:0] operand_b;
        logic [umdu_pkg::FIELD_W-1:0] result;
    } op_record_t;

    op_record_t results_due[$];

    // A zero divisor gives all ones for both quotient and remainder.
    function automatic logic [umdu_pkg::FIELD_W-1:0] umdu_result(
        input logic [umdu_pkg::KIND_W-1:0]  kind,
        input logic [umdu_pkg::FIELD_W-1:0] a,
        input logic [umdu_pkg::FIELD_W-1:0] b
    );
        logic [umdu_pkg::FIELD_W-1:0] value;
        case (kind)
            umdu_pkg::KIND_MUL: value = a * b;
            umdu_pkg::KIND_QUO: value = (b == '0) ? '1 : a / b;
            umdu_pkg::KIND_REM: value = (b == '0) ? '1 : a % b;
            default:            value = '0;
        endcase
        return value;
    endfunction

    always @(posedge clk)
    begin : track
        op_record_t rec;
        if (!rst_n)
        begin
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result transaction: expected none, actual %h",
                             $time, m_axis_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    rec = results_due.pop_front();
                    if (m_axis_tdata !== rec.result)
                    begin
                        $display("%0t: kind %0d a %h b %h: expected %h, actual %h",
                                 $time, rec.kind, rec.operand_a, rec.operand_b,
                                 rec.result, m_axis_tdata);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                rec.kind      = s_axis_tuser;
                rec.operand_a = s_axis_tdata[31:0];
                rec.operand_b = s_axis_tdata[63:32];
                rec.result    = umdu_result(rec.kind, rec.operand_a, rec.operand_b);
                results_due.push_back(rec);
            end
            pending <= results_due.size();
        end
    end

endmodule

// File: sim/testbench.sv
// ============================================================================
// testbench: stimulus and verdict for the unsigned multiply/divide unit
// Sends directed corner cases and then randomly shaped operations through
// the unit with random gaps and output stalls, and reports the outcome of
// the checker once every result has come back.
// ============================================================================

module testbench;

    localparam logic [umdu_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1030;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    int          errors;
    int          pending;
    int          stall_cycles = 0;
    logic        no_idle = 1'b0;
    logic [2:0]  rx_hold = '0;

    always #1 clk = ~clk;

    unsigned_mul_div_unit_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mul_div_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    // The receiver holds off for a random wait after each result, or not at all while no_idle is set.
    always @(posedge clk)
    begin : result_sink
        int unsigned wait_cycles;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                wait_cycles = no_idle ? 0 : $urandom_range(0, 7);
                rx_hold <= 3'(wait_cycles);
                m_axis_tready <= (wait_cycles == 0);
            end
            else if (rx_hold != 3'd0)
            begin
                rx_hold <= rx_hold - 3'd1;
                m_axis_tready <= (rx_hold == 3'd1);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_op(
        input logic [umdu_pkg::KIND_W-1:0]  kind,
        input logic [umdu_pkg::FIELD_W-1:0] a,
        input logic [umdu_pkg::FIELD_W-1:0] b
    );
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [umdu_pkg::FIELD_W-1:0] draw_operand();
        logic [umdu_pkg::FIELD_W-1:0] value;
        int unsigned shift;
        shift = $urandom_range(0, umdu_pkg::FIELD_W - 1);
        case ($urandom_range(0, 15))
            0:       value = '0;
            1:       value = '1;
            2, 3:    value = $urandom_range(0, 255);
            4:       value = 32'd1 << shift;
            5:       value = (32'd1 << shift) - 1;
            6:       value = 32'h8000_0000 | $urandom;
            7:       value = $urandom >> shift;
            default: value = $urandom;
        endcase
        return value;
    endfunction

    initial
    begin : stimulus
        logic [umdu_pkg::KIND_W-1:0]  kind;
        logic [umdu_pkg::FIELD_W-1:0] a;
        logic [umdu_pkg::FIELD_W-1:0] b;
        int unsigned                  pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(umdu_pkg::KIND_MUL, 32'h0000_0000, 32'h0000_0000);
        send_op(umdu_pkg::KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(umdu_pkg::KIND_MUL, 32'h1234_5678, 32'h0000_0001);
        send_op(umdu_pkg::KIND_MUL, 32'h8000_0000, 32'h0000_0002);
        send_op(umdu_pkg::KIND_MUL, 32'h0000_FFFF, 32'h0001_0001);
        send_op(umdu_pkg::KIND_QUO, 32'hFFFF_FFFF, 32'h0000_0001);
        send_op(umdu_pkg::KIND_QUO, 32'h0000_1234, 32'h0000_0000);
        send_op(umdu_pkg::KIND_QUO, 32'h0000_0000, 32'h0000_0000);
        send_op(umdu_pkg::KIND_QUO, 32'h0000_0005, 32'h0000_0007);
        send_op(umdu_pkg::KIND_QUO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(umdu_pkg::KIND_QUO, 32'h8000_0000, 32'h0000_0003);
        send_op(umdu_pkg::KIND_QUO, 32'hFFFF_FFFF, 32'h8000_0000);
        send_op(umdu_pkg::KIND_REM, 32'h0000_1234, 32'h0000_0000);
        send_op(umdu_pkg::KIND_REM, 32'h0000_0000, 32'h0000_0000);
        send_op(umdu_pkg::KIND_REM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(umdu_pkg::KIND_REM, 32'hFFFF_FFFF, 32'h0000_0010);
        send_op(umdu_pkg::KIND_REM, 32'h0000_0007, 32'h0000_0005);
        send_op(umdu_pkg::KIND_REM, 32'h8000_0001, 32'h8000_0000);
        send_op(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(KIND_UNUSED, 32'h0000_0000, 32'h0000_0000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle <= ((i / 128) % 4 == 3);
            pick = $urandom_range(0, 15);
            if (pick < 5)
                kind = umdu_pkg::KIND_MUL;
            else if (pick < 10)
                kind = umdu_pkg::KIND_QUO;
            else if (pick < 15)
                kind = umdu_pkg::KIND_REM;
            else
                kind = KIND_UNUSED;
            a = draw_operand();
            case ($urandom_range(0, 7))
                0:       b = a >> $urandom_range(0, umdu_pkg::FIELD_W - 1);
                1:       b = a;
                2:       b = a + 1;
                default: b = draw_operand();
            endcase
            send_op(kind, a, b);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
